/* sv/led_matrix_frame_serializer_top_macros.svh */
// ----------------------------------------------------------------------------
// led_matrix_frame_serializer_top_macros
// assertion macros shared by the frame serializer
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_FRAME_SERIALIZER_TOP_MACROS_SVH
`define LED_MATRIX_FRAME_SERIALIZER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LMFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lmfs assertion failed");

// next-cycle implication, checked out of reset
`define LMFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lmfs assertion failed");

`endif

/* sv/lmfs_pkg.sv */
// ----------------------------------------------------------------------------
// lmfs_pkg
// types, constants and command tables of the LED matrix frame serializer
// ----------------------------------------------------------------------------
package lmfs_pkg;

    localparam int STORE_BYTES = 48;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);

    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMON_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMON_MODE  = 2'd2;

    localparam logic [5:0] ROW_COUNT_RESET    = 6'd32;
    localparam logic [4:0] COMMON_COUNT_RESET = 5'd8;
    localparam logic [1:0] COMMON_MODE_RESET  = 2'd0;

    localparam logic [2:0]  CMD_PREFIX      = 3'b100;
    localparam logic [11:0] UPD_HEADER      = 12'h280;
    localparam logic [3:0]  CMD_BITS        = 4'd12;
    localparam logic [3:0]  HDR_BITS        = 4'd10;
    localparam logic [3:0]  BYTE_BITS       = 4'd8;
    localparam logic [3:0]  LEVEL_MAX       = 4'd15;
    localparam logic [8:0]  CMD_BRIGHT_BASE = 9'h140;
    localparam logic [8:0]  CMD_BLINK_BASE  = 9'h010;

    localparam logic [8:0] CMD_INIT_SYS_EN  = 9'b000110000;
    localparam logic [8:0] CMD_INIT_LED_OFF = 9'b000010000;
    localparam logic [8:0] CMD_INIT_COM     = 9'b001000000;
    localparam logic [8:0] CMD_INIT_MASTER  = 9'b101011110;
    localparam logic [8:0] CMD_INIT_SYS_ON  = 9'b000000010;
    localparam logic [8:0] CMD_INIT_LED_ON  = 9'b000000110;
    localparam int         INIT_WORDS       = 6;

    typedef enum logic [2:0] {
        FUNC_PIXEL  = 3'd0,
        FUNC_FILL   = 3'd1,
        FUNC_BRIGHT = 3'd2,
        FUNC_BLINK  = 3'd3,
        FUNC_UPDATE = 3'd4,
        FUNC_INIT   = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_FILL,
        ST_CMD,
        ST_UPD_HDR,
        ST_UPD_BYTE
    } state_t;

    typedef enum logic [1:0] {
        OUT_CMD,
        OUT_HDR,
        OUT_BYTE
    } out_sel_t;

    typedef struct packed {
        logic     capture;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     mem_rd;
        logic     mem_wr;
        logic     addr_pix;
        logic     out_load;
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  pix_ok;
        logic  n_zero;
        logic  fill_last;
        logic  init_last;
        logic  upd_last;
        logic  out_free;
    } dp_sts_t;

    // init sequence, common mode code sits in bits 4:3 of the third word
    function automatic logic [8:0] init_cmd(input logic [2:0] idx, input logic [1:0] mode);
        logic [8:0] cmd;
        case (idx)
            3'd0:    cmd = CMD_INIT_SYS_EN;
            3'd1:    cmd = CMD_INIT_LED_OFF;
            3'd2:    cmd = CMD_INIT_COM | {4'b0000, mode, 3'b000};
            3'd3:    cmd = CMD_INIT_MASTER;
            3'd4:    cmd = CMD_INIT_SYS_ON;
            default: cmd = CMD_INIT_LED_ON;
        endcase
        return cmd;
    endfunction

endpackage

/* sv/lmfs_ctrl.sv */
// ----------------------------------------------------------------------------
// lmfs_ctrl
// sequencer for request decode, store sweeps and word emission
// ----------------------------------------------------------------------------
module lmfs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [2:0]            s_func,
    output logic                  s_ready,
    input  lmfs_pkg::dp_sts_t     sts,
    output lmfs_pkg::ctrl_cmd_t   cmd
);

    lmfs_pkg::state_t state_reg;
    lmfs_pkg::state_t state_next;
    logic             accept;

    assign s_ready = (state_reg == lmfs_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lmfs_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_func) inside
                        lmfs_pkg::FUNC_PIXEL:  state_next = lmfs_pkg::ST_PIX_RD;
                        lmfs_pkg::FUNC_FILL:   state_next = sts.n_zero ? lmfs_pkg::ST_IDLE
                                                                       : lmfs_pkg::ST_FILL;
                        lmfs_pkg::FUNC_UPDATE: state_next = lmfs_pkg::ST_UPD_HDR;
                        lmfs_pkg::FUNC_BRIGHT,
                        lmfs_pkg::FUNC_BLINK,
                        lmfs_pkg::FUNC_INIT:   state_next = lmfs_pkg::ST_CMD;
                        default:               state_next = lmfs_pkg::ST_IDLE;
                    endcase
                end
            end
            lmfs_pkg::ST_PIX_RD: begin
                state_next = sts.pix_ok ? lmfs_pkg::ST_PIX_WR : lmfs_pkg::ST_IDLE;
            end
            lmfs_pkg::ST_PIX_WR: begin
                state_next = lmfs_pkg::ST_IDLE;
            end
            lmfs_pkg::ST_FILL: begin
                if (sts.fill_last) begin
                    state_next = lmfs_pkg::ST_IDLE;
                end
            end
            lmfs_pkg::ST_CMD: begin
                if (sts.out_free && (sts.func != lmfs_pkg::FUNC_INIT || sts.init_last)) begin
                    state_next = lmfs_pkg::ST_IDLE;
                end
            end
            lmfs_pkg::ST_UPD_HDR: begin
                if (sts.out_free) begin
                    state_next = sts.n_zero ? lmfs_pkg::ST_IDLE : lmfs_pkg::ST_UPD_BYTE;
                end
            end
            lmfs_pkg::ST_UPD_BYTE: begin
                if (sts.out_free && sts.upd_last) begin
                    state_next = lmfs_pkg::ST_IDLE;
                end
            end
            default: state_next = lmfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.out_sel  = lmfs_pkg::OUT_CMD;
        unique case (state_reg)
            lmfs_pkg::ST_IDLE: begin
                cmd.capture = accept;
                cmd.cnt_clr = accept;
            end
            lmfs_pkg::ST_PIX_RD: begin
                cmd.addr_pix = 1'b1;
                cmd.mem_rd   = sts.pix_ok;
            end
            lmfs_pkg::ST_PIX_WR: begin
                cmd.addr_pix = 1'b1;
                cmd.mem_wr   = 1'b1;
            end
            lmfs_pkg::ST_FILL: begin
                cmd.mem_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            lmfs_pkg::ST_CMD: begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = lmfs_pkg::OUT_CMD;
                cmd.cnt_inc  = sts.out_free;
            end
            lmfs_pkg::ST_UPD_HDR: begin
                // first byte is fetched alongside the header
                cmd.out_load = sts.out_free;
                cmd.out_sel  = lmfs_pkg::OUT_HDR;
                cmd.mem_rd   = sts.out_free && !sts.n_zero;
                cmd.cnt_inc  = sts.out_free && !sts.n_zero;
            end
            lmfs_pkg::ST_UPD_BYTE: begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = lmfs_pkg::OUT_BYTE;
                cmd.mem_rd   = sts.out_free && !sts.upd_last;
                cmd.cnt_inc  = sts.out_free && !sts.upd_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* sv/lmfs_datapath.sv */
// ----------------------------------------------------------------------------
// lmfs_datapath
// configuration registers, frame store, sweep counter and output register
// ----------------------------------------------------------------------------
module lmfs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lmfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lmfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [2:0]                          s_func,
    input  logic [4:0]                          s_row_sel,
    input  logic [3:0]                          s_com_sel,
    input  logic                                s_pixel_on,
    input  logic [7:0]                          s_fill_pattern,
    input  logic [7:0]                          s_level,
    input  logic                                s_blink_on,
    input  lmfs_pkg::ctrl_cmd_t                 cmd,
    output lmfs_pkg::dp_sts_t                   sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [11:0]                         m_word,
    output logic [3:0]                          m_word_bits,
    output logic                                m_lsb_first,
    output logic                                m_frame_start,
    output logic                                m_frame_end,
    output logic                                m_last
);

    logic [5:0] row_count_reg;
    logic [4:0] common_count_reg;
    logic [1:0] common_mode_reg;

    lmfs_pkg::func_t func_reg;
    logic [4:0]      row_reg;
    logic [3:0]      com_reg;
    logic            on_reg;
    logic [7:0]      pattern_reg;
    logic [7:0]      level_reg;
    logic            blink_reg;

    logic [lmfs_pkg::CNT_W-1:0] cnt_reg;
    logic [7:0]                 mem [lmfs_pkg::STORE_BYTES];
    logic [7:0]                 rdata_reg;

    logic                       valid_reg;
    logic [11:0]                word_reg;
    logic [3:0]                 bits_reg;
    logic                       lsb_reg;
    logic                       start_reg;
    logic                       end_reg;
    logic                       last_reg;

    logic [10:0]                cells;
    logic [7:0]                 used_raw;
    logic [lmfs_pkg::CNT_W-1:0] used_bytes;
    logic [7:0]                 pix_idx;
    logic [lmfs_pkg::ADDR_W-1:0] addr;
    logic [7:0]                 pix_byte;
    logic [7:0]                 wdata;
    logic [3:0]                 level_sat;
    logic [8:0]                 cmd_word;
    logic                       out_free;

    // used byte count, saturated at the store size
    assign cells      = 11'(row_count_reg) * 11'(common_count_reg);
    assign used_raw   = cells[10:3];
    assign used_bytes = (used_raw > 8'(lmfs_pkg::STORE_BYTES))
                        ? lmfs_pkg::CNT_W'(lmfs_pkg::STORE_BYTES)
                        : lmfs_pkg::CNT_W'(used_raw);

    assign pix_idx = 8'(com_reg[3]) + 8'(7'(row_reg) * 7'(common_count_reg[4:3]));

    assign addr  = cmd.addr_pix ? pix_idx[lmfs_pkg::ADDR_W-1:0]
                                : cnt_reg[lmfs_pkg::ADDR_W-1:0];

    always_comb begin
        pix_byte = rdata_reg;
        pix_byte[com_reg[2:0]] = on_reg;
    end

    assign wdata = cmd.addr_pix ? pix_byte : pattern_reg;

    assign level_sat = (level_reg > 8'(lmfs_pkg::LEVEL_MAX)) ? lmfs_pkg::LEVEL_MAX
                                                             : level_reg[3:0];

    always_comb begin
        case (func_reg)
            lmfs_pkg::FUNC_BRIGHT: cmd_word = lmfs_pkg::CMD_BRIGHT_BASE
                                              | {4'b0000, level_sat, 1'b0};
            lmfs_pkg::FUNC_BLINK:  cmd_word = lmfs_pkg::CMD_BLINK_BASE
                                              | {7'b0000000, blink_reg, 1'b0};
            default:               cmd_word = lmfs_pkg::init_cmd(cnt_reg[2:0], common_mode_reg);
        endcase
    end

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        sts           = '0;
        sts.func      = func_reg;
        sts.pix_ok    = (pix_idx < 8'(lmfs_pkg::STORE_BYTES));
        sts.n_zero    = (used_bytes == '0);
        sts.fill_last = ((cnt_reg + lmfs_pkg::CNT_W'(1)) == used_bytes);
        sts.init_last = (cnt_reg == lmfs_pkg::CNT_W'(lmfs_pkg::INIT_WORDS - 1));
        sts.upd_last  = (cnt_reg == used_bytes);
        sts.out_free  = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= lmfs_pkg::ROW_COUNT_RESET;
            common_count_reg <= lmfs_pkg::COMMON_COUNT_RESET;
            common_mode_reg  <= lmfs_pkg::COMMON_MODE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lmfs_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                lmfs_pkg::CFG_COMMON_COUNT: common_count_reg <= cfg_wdata[4:0];
                lmfs_pkg::CFG_COMMON_MODE:  common_mode_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg    <= lmfs_pkg::func_t'(s_func);
            row_reg     <= s_row_sel;
            com_reg     <= s_com_sel;
            on_reg      <= s_pixel_on;
            pattern_reg <= s_fill_pattern;
            level_reg   <= s_level;
            blink_reg   <= s_blink_on;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + lmfs_pkg::CNT_W'(1);
        end
    end

    // frame store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[addr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_sel)
                lmfs_pkg::OUT_HDR: begin
                    word_reg  <= lmfs_pkg::UPD_HEADER;
                    bits_reg  <= lmfs_pkg::HDR_BITS;
                    lsb_reg   <= 1'b0;
                    start_reg <= 1'b1;
                    end_reg   <= sts.n_zero;
                    last_reg  <= sts.n_zero;
                end
                lmfs_pkg::OUT_BYTE: begin
                    word_reg  <= {4'b0000, rdata_reg};
                    bits_reg  <= lmfs_pkg::BYTE_BITS;
                    lsb_reg   <= 1'b1;
                    start_reg <= 1'b0;
                    end_reg   <= sts.upd_last;
                    last_reg  <= sts.upd_last;
                end
                default: begin
                    word_reg  <= {lmfs_pkg::CMD_PREFIX, cmd_word};
                    bits_reg  <= lmfs_pkg::CMD_BITS;
                    lsb_reg   <= 1'b0;
                    start_reg <= 1'b1;
                    end_reg   <= 1'b1;
                    last_reg  <= (func_reg != lmfs_pkg::FUNC_INIT) || sts.init_last;
                end
            endcase
        end
    end

    assign m_valid       = valid_reg;
    assign m_word        = word_reg;
    assign m_word_bits   = bits_reg;
    assign m_lsb_first   = lsb_reg;
    assign m_frame_start = start_reg;
    assign m_frame_end   = end_reg;
    assign m_last        = last_reg;

endmodule

/* sv/led_matrix_frame_serializer_top.sv */
// ----------------------------------------------------------------------------
// led_matrix_frame_serializer_top
// LED matrix frame store and serial word generator for a three-wire link
// ----------------------------------------------------------------------------
// The host hands requests over the s_ channel, one transfer per request.
// Pixel and fill requests only change the frame store; brightness, blink,
// init and update requests produce words on the m_ channel, each word with
// its bit count, shift order and chip select framing, m_last on the final one.
// A command word is loaded into the output register from the command state
// that follows the request's acceptance, once that register is free. After
// the request is taken in the idle state, set pixel passes a store read
// state then a write state (only the read state when out of range), fill
// writes one used byte per cycle, brightness and blink send 1 word, init 6
// words, update the header plus one word per used byte; with the receiver
// always ready one word goes out per cycle. The next request is taken as
// soon as the last word sits in the output register. If the receiver stalls,
// the output register holds its word and the sequencer waits; nothing is
// dropped. Configuration writes (cfg_) are to be made only while no request
// is in progress. Reset restores the configuration defaults and empties the
// output; the store is not cleared.
// ----------------------------------------------------------------------------
`include "led_matrix_frame_serializer_top_macros.svh"

module led_matrix_frame_serializer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lmfs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lmfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_func,
    input  logic [4:0]                        s_row_sel,
    input  logic [3:0]                        s_com_sel,
    input  logic                              s_pixel_on,
    input  logic [7:0]                        s_fill_pattern,
    input  logic [7:0]                        s_level,
    input  logic                              s_blink_on,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [11:0]                       m_word,
    output logic [3:0]                        m_word_bits,
    output logic                              m_lsb_first,
    output logic                              m_frame_start,
    output logic                              m_frame_end,
    output logic                              m_last
);

    lmfs_pkg::ctrl_cmd_t cmd;
    lmfs_pkg::dp_sts_t   sts;

    lmfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lmfs_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_func         (s_func),
        .s_row_sel      (s_row_sel),
        .s_com_sel      (s_com_sel),
        .s_pixel_on     (s_pixel_on),
        .s_fill_pattern (s_fill_pattern),
        .s_level        (s_level),
        .s_blink_on     (s_blink_on),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_word         (m_word),
        .m_word_bits    (m_word_bits),
        .m_lsb_first    (m_lsb_first),
        .m_frame_start  (m_frame_start),
        .m_frame_end    (m_frame_end),
        .m_last         (m_last)
    );

    // a new word never overwrites one still waiting for its transfer
    `LMFS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, sts.out_free)
    // pixel writes stay inside the store
    `LMFS_ASSERT_IMP(a_pix_in_range, aclk, aresetn, cmd.mem_wr && cmd.addr_pix, sts.pix_ok)
    // a request is not finished while a non-final word is pending
    `LMFS_ASSERT_IMP(a_busy_mid_item, aclk, aresetn, m_valid && !m_last, !s_ready)
    // an update always leaves idle to send its header
    `LMFS_ASSERT_NEXT(a_update_busy, aclk, aresetn,
        s_valid && s_ready && (s_func == lmfs_pkg::FUNC_UPDATE), !s_ready)

endmodule
